FILE: sv/vbpt_pkg.sv
package vbpt_pkg;

    // field lengths in system clock ticks
    localparam logic [17:0] FIELD_PAL_LONG   = 18'd142415;
    localparam logic [17:0] FIELD_PAL_SHORT  = 18'd141960;
    localparam logic [17:0] FIELD_NTSC_LONG  = 18'd119665;
    localparam logic [17:0] FIELD_NTSC_SHORT = 18'd119210;

    // one long plus one short field
    localparam int          MOD_W            = 19;
    localparam logic [18:0] PAIR_PAL         = 19'd284375;
    localparam logic [18:0] PAIR_NTSC        = 19'd238875;

    // line divisor 456 = 8 * 57, quotient by reciprocal of 57
    localparam logic [14:0] RECIP_MULT       = 15'd18397;
    localparam int          RECIP_SHIFT      = 20;

    // configuration register indexes
    localparam logic        CFG_PAL_MODE     = 1'b0;
    localparam logic        CFG_INTERLACE_ON = 1'b1;

    function automatic logic [17:0] field_len(input logic pal, input logic lng);
        logic [17:0] len;
        if (pal)
        begin
            len = lng ? FIELD_PAL_LONG : FIELD_PAL_SHORT;
        end
        else
        begin
            len = lng ? FIELD_NTSC_LONG : FIELD_NTSC_SHORT;
        end
        return len;
    endfunction

    function automatic logic [18:0] pair_len(input logic pal);
        return pal ? PAIR_PAL : PAIR_NTSC;
    endfunction

endpackage

FILE: sv/vbpt_sub_unit.sv
module vbpt_sub_unit #(
    parameter int WIDTH = 29
) (
    input  logic [WIDTH-1:0] minuend,
    input  logic [WIDTH-1:0] subtrahend,
    output logic             no_borrow,
    output logic [WIDTH-1:0] diff
);

    logic [WIDTH:0] full_diff;

    // shared compare and subtract
    assign full_diff = {1'b0, minuend} - {1'b0, subtrahend};
    assign no_borrow = ~full_diff[WIDTH];
    assign diff      = full_diff[WIDTH-1:0];

endmodule

FILE: sv/vbpt_line_div.sv
module vbpt_line_div import vbpt_pkg::*; (
    input  logic        clk,
    input  logic        load,
    input  logic [17:0] pos,
    output logic [8:0]  line_number,
    output logic [8:0]  line_offset
);

    logic [29:0] prod;
    logic [8:0]  q_reg;
    logic [8:0]  q_next;
    logic [17:0] q_scaled;
    logic [17:0] rem;

    // quotient by 456: drop three bits, then reciprocal of 57
    assign prod   = 30'(pos[17:3]) * 30'(RECIP_MULT);
    assign q_next = prod[RECIP_SHIFT +: 9];

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            q_reg <= q_next;
        end
    end

    // remainder: 456 = 512 - 64 + 8
    assign q_scaled    = (18'(q_reg) << 9) - (18'(q_reg) << 6) + (18'(q_reg) << 3);
    assign rem         = pos - q_scaled;
    assign line_number = q_reg;
    assign line_offset = rem[8:0];

endmodule

FILE: sv/video_beam_position_timebase_unit.sv
// Video beam timebase. Each request carries the system clock ticks elapsed since the
// previous query; the block advances its position within the current video field, wraps
// through whole fields (long and short alternating with interlace on, always long with
// interlace off) and returns the long-field flag, line number and offset in units of 456
// ticks, and the ticks left to the end of the field. The wrap is a shift-and-subtract
// reduction on one shared subtractor, one conditional step for each of the
// max(DELTA_WIDTH, 16) - 14 shifted multiples, then one field step, the line quotient
// and the result load. The next request is taken the cycle after the load. Only one
// request is in flight at a time; a result held in the output register delays the
// load of the next one.
module video_beam_position_timebase_unit import vbpt_pkg::*; #(
    parameter int DELTA_WIDTH = 24
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic                   cfg_index,
    input  logic                   cfg_data,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [DELTA_WIDTH-1:0] elapsed_ticks,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   long_field_flag,
    output logic [8:0]             line_number,
    output logic [8:0]             line_offset,
    output logic [17:0]            ticks_to_field_end
);

    localparam int DWX  = (DELTA_WIDTH > 16) ? DELTA_WIDTH : 16;
    localparam int UW   = DWX + 5;
    localparam int KMAX = DWX - 15;
    localparam int KW   = $clog2(KMAX + 1);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_REDUCE = 3'd1;
    localparam logic [2:0] ST_WRAP   = 3'd2;
    localparam logic [2:0] ST_DIV    = 3'd3;
    localparam logic [2:0] ST_LOAD   = 3'd4;

    logic [2:0]    state_reg, state_next;
    logic [UW-1:0] pos_reg, pos_next;
    logic [KW-1:0] k_reg, k_next;
    logic          long_reg, long_next;
    logic [17:0]   field_pos_reg, field_pos_next;
    logic          pal_reg, interlace_reg;
    logic          out_valid_reg, out_valid_next;
    logic          long_out_reg;
    logic [8:0]    line_number_reg, line_offset_reg;
    logic [17:0]   ticks_reg;

    logic [MOD_W-1:0] modulus;
    logic [17:0]      cur_len;
    logic [UW-1:0]    operand;
    logic             ge;
    logic [UW-1:0]    diff;
    logic [8:0]       div_line;
    logic [8:0]       div_offset;
    logic             out_load;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pal_reg       <= 1'b1;
            interlace_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_PAL_MODE:     pal_reg       <= cfg_data;
                CFG_INTERLACE_ON: interlace_reg <= cfg_data;
                default:          pal_reg       <= pal_reg;
            endcase
        end
    end

    // reduction modulus and current field length
    assign modulus = interlace_reg ? pair_len(pal_reg) : MOD_W'(field_len(pal_reg, 1'b1));
    assign cur_len = field_len(pal_reg, long_reg);
    assign operand = (state_reg == ST_REDUCE) ? (UW'(modulus) << k_reg) : UW'(cur_len);

    vbpt_sub_unit #(
        .WIDTH(UW)
    ) u_sub (
        .minuend    (pos_reg),
        .subtrahend (operand),
        .no_borrow  (ge),
        .diff       (diff)
    );

    vbpt_line_div u_line_div (
        .clk         (clk),
        .load        (state_reg == ST_DIV),
        .pos         (pos_reg[17:0]),
        .line_number (div_line),
        .line_offset (div_offset)
    );

    assign in_ready = (state_reg == ST_IDLE);
    assign out_load = (state_reg == ST_LOAD) && (!out_valid_reg || out_ready);

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        k_next         = k_reg;
        long_next      = long_reg;
        field_pos_next = field_pos_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    pos_next   = UW'(field_pos_reg) + UW'(elapsed_ticks);
                    long_next  = interlace_reg ? long_reg : 1'b1;
                    k_next     = KW'(KMAX);
                    state_next = ST_REDUCE;
                end
            end
            ST_REDUCE:
            begin
                if (ge)
                begin
                    pos_next = diff;
                end
                if (k_reg == '0)
                begin
                    state_next = ST_WRAP;
                end
                else
                begin
                    k_next = k_reg - KW'(1);
                end
            end
            ST_WRAP:
            begin
                if (ge)
                begin
                    pos_next  = diff;
                    long_next = interlace_reg ? ~long_reg : long_reg;
                end
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (out_load)
                begin
                    field_pos_next = pos_reg[17:0];
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    // control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            long_reg      <= 1'b1;
            field_pos_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            long_reg      <= long_next;
            field_pos_reg <= field_pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        pos_reg <= pos_next;
        k_reg   <= k_next;
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            long_out_reg    <= long_reg;
            line_number_reg <= div_line;
            line_offset_reg <= div_offset;
            ticks_reg       <= cur_len - pos_reg[17:0];
        end
    end

    assign out_valid          = out_valid_reg;
    assign long_field_flag    = long_out_reg;
    assign line_number        = line_number_reg;
    assign line_offset        = line_offset_reg;
    assign ticks_to_field_end = ticks_reg;

    // reduction leaves the position below one modulus
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WRAP) |-> (pos_reg < UW'(modulus)))
        else $error("position not reduced before field wrap");

    // position lies inside the field when the result is loaded
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOAD) |-> (pos_reg < UW'(cur_len)))
        else $error("position beyond field length at result load");

    // a shown result never sits exactly at the field end, and its offset is below 456
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (ticks_reg != 18'd0) && (line_offset_reg < 9'd456))
        else $error("result out of range");

    // without interlace every field is long
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !interlace_reg) |-> long_out_reg)
        else $error("short field with interlace off");

endmodule

FILE: verif/beam_timebase_checker.sv
module beam_timebase_checker import vbpt_pkg::*; #(
    parameter int DELTA_WIDTH = 24
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic                   cfg_index,
    input  logic                   cfg_data,
    input  logic                   in_valid,
    input  logic                   in_ready,
    input  logic [DELTA_WIDTH-1:0] elapsed_ticks,
    input  logic                   out_valid,
    input  logic                   out_ready,
    input  logic                   long_field_flag,
    input  logic [8:0]             line_number,
    input  logic [8:0]             line_offset,
    input  logic [17:0]            ticks_to_field_end,
    output int                     mismatch_count,
    output int                     pending_count
);

    // lines are counted in 456-tick units
    localparam int unsigned LINE_TICKS = 456;

    typedef struct packed {
        logic        long_flag;
        logic [8:0]  line;
        logic [8:0]  offset;
        logic [17:0] ticks_left;
    } beam_pos_t;

    // shadow of the configuration and of the beam position
    logic        pal_mode;
    logic        interlace_on;
    logic        long_field;
    logic [17:0] field_position;

    beam_pos_t   expected_beam_q[$];
    beam_pos_t   oldest_beam;

    // add elapsed ticks to the field position and wrap through whole fields
    function automatic beam_pos_t advance_beam(input logic [DELTA_WIDTH-1:0] ticks);
        int unsigned pos;
        int unsigned len;
        beam_pos_t   beam;
        if (!interlace_on)
        begin
            long_field = 1'b1;
        end
        pos = 32'(field_position) + 32'(ticks);
        forever
        begin
            if (pal_mode)
            begin
                len = long_field ? FIELD_PAL_LONG : FIELD_PAL_SHORT;
            end
            else
            begin
                len = long_field ? FIELD_NTSC_LONG : FIELD_NTSC_SHORT;
            end
            if (pos < len)
            begin
                break;
            end
            pos -= len;
            if (interlace_on)
            begin
                long_field = ~long_field;
            end
        end
        field_position  = pos[17:0];
        beam.long_flag  = long_field;
        beam.line       = 9'(pos / LINE_TICKS);
        beam.offset     = 9'(pos % LINE_TICKS);
        beam.ticks_left = 18'(len - pos);
        return beam;
    endfunction

    task automatic check_field(input string name, input logic [17:0] want,
                               input logic [17:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pal_mode       = 1'b1;
            interlace_on   = 1'b0;
            long_field     = 1'b1;
            field_position = '0;
            mismatch_count = 0;
            pending_count  = 0;
            expected_beam_q.delete();
        end
        else
        begin
            // register writes
            if (cfg_we)
            begin
                if (cfg_index == CFG_PAL_MODE)
                begin
                    pal_mode = cfg_data;
                end
                else if (cfg_index == CFG_INTERLACE_ON)
                begin
                    interlace_on = cfg_data;
                end
            end

            // result against the oldest outstanding request
            if (out_valid && out_ready)
            begin
                if (expected_beam_q.size() == 0)
                begin
                    $error("result with no outstanding request: line %0d offset %0d",
                           line_number, line_offset);
                    mismatch_count++;
                end
                else
                begin
                    oldest_beam = expected_beam_q.pop_front();
                    check_field("long_field_flag", 18'(oldest_beam.long_flag),
                                18'(long_field_flag));
                    check_field("line_number", 18'(oldest_beam.line), 18'(line_number));
                    check_field("line_offset", 18'(oldest_beam.offset), 18'(line_offset));
                    check_field("ticks_to_field_end", oldest_beam.ticks_left,
                                ticks_to_field_end);
                end
            end

            // new request
            if (in_valid && in_ready)
            begin
                expected_beam_q.push_back(advance_beam(elapsed_ticks));
            end
            pending_count = expected_beam_q.size();
        end
    end

endmodule

FILE: verif/testbench.sv
module testbench;
    import vbpt_pkg::*;

    localparam int DELTA_WIDTH       = 24;
    localparam int RUN_LIMIT         = 5_000_000;
    localparam int SEGMENTS          = 6;
    localparam int ITEMS_PER_SEGMENT = 330;

    // per-segment setting, bit i belongs to segment i
    localparam bit [SEGMENTS-1:0] SEG_PAL       = 6'b010110;
    localparam bit [SEGMENTS-1:0] SEG_INTERLACE = 6'b010011;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_we;
    logic                   cfg_index;
    logic                   cfg_data;
    logic                   in_valid;
    logic                   in_ready;
    logic [DELTA_WIDTH-1:0] elapsed_ticks;
    logic                   out_valid;
    logic                   out_ready;
    logic                   long_field_flag;
    logic [8:0]             line_number;
    logic [8:0]             line_offset;
    logic [17:0]            ticks_to_field_end;

    int mismatch_count;
    int pending_count;
    int sender_idle_pct    = 27;
    int receiver_stall_pct = 47;

    video_beam_position_timebase_unit #(
        .DELTA_WIDTH(DELTA_WIDTH)
    ) dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .elapsed_ticks      (elapsed_ticks),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .long_field_flag    (long_field_flag),
        .line_number        (line_number),
        .line_offset        (line_offset),
        .ticks_to_field_end (ticks_to_field_end)
    );

    beam_timebase_checker #(
        .DELTA_WIDTH(DELTA_WIDTH)
    ) beam_check (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .elapsed_ticks      (elapsed_ticks),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .long_field_flag    (long_field_flag),
        .line_number        (line_number),
        .line_offset        (line_offset),
        .ticks_to_field_end (ticks_to_field_end),
        .mismatch_count     (mismatch_count),
        .pending_count      (pending_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // one request, with random idle cycles ahead of it
    task automatic send_delta(input logic [DELTA_WIDTH-1:0] ticks);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid      <= 1'b1;
        elapsed_ticks <= ticks;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    // hold off until every outstanding result has been taken
    task automatic drain_requests();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending_count != 0)
        begin
            @(negedge clk);
        end
    endtask

    task automatic write_setting(input logic pal, input logic interlace);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_PAL_MODE;
        cfg_data  <= pal;
        @(negedge clk);
        cfg_index <= CFG_INTERLACE_ON;
        cfg_data  <= interlace;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // receiver stalls
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            out_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
        end
    end

    initial
    begin
        #(RUN_LIMIT);
        $display("FAIL");
        $finish;
    end

    initial
    begin
        logic [DELTA_WIDTH-1:0] ticks;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = CFG_PAL_MODE;
        cfg_data      = 1'b0;
        in_valid      = 1'b0;
        elapsed_ticks = '0;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        // reset setting: pal, long fields only; last line, exact wraps
        send_delta(0);
        send_delta(142414);
        send_delta(1);
        send_delta(142415);
        send_delta(130000);

        // switch to ntsc with the position past the new field end
        drain_requests();
        write_setting(1'b0, 1'b0);
        send_delta(455);

        // ntsc interlaced, all-ones and alternating input bits
        drain_requests();
        write_setting(1'b0, 1'b1);
        send_delta(24'hFFFFFF);
        send_delta(24'hAAAAAA);
        send_delta(24'h555555);
        send_delta(24'h800000);
        send_delta(456);
        send_delta(238875);

        // pal interlaced, long and short field wraps
        drain_requests();
        write_setting(1'b1, 1'b1);
        send_delta(142415);
        send_delta(141960);
        send_delta(0);
        send_delta(457);
        send_delta(284375);

        // random traffic, one setting and idle mix per segment
        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            drain_requests();
            write_setting(SEG_PAL[seg], SEG_INTERLACE[seg]);
            sender_idle_pct    = (seg < 2) ? 27 : ((seg < 4) ? 47 : 0);
            receiver_stall_pct = (seg < 2) ? 47 : ((seg < 4) ? 27 : 0);
            repeat (ITEMS_PER_SEGMENT)
            begin
                case ($urandom_range(0, 3))
                    0:       ticks = DELTA_WIDTH'($urandom_range(0, 2000));
                    1:       ticks = DELTA_WIDTH'($urandom_range(0, 300000));
                    2:       ticks = DELTA_WIDTH'($urandom());
                    default: ticks = DELTA_WIDTH'($urandom_range(1, 100) * FIELD_NTSC_SHORT
                                                  + $urandom_range(0, 3));
                endcase
                send_delta(ticks);
                if ($urandom_range(0, 49) == 0)
                begin
                    drain_requests();
                end
            end
        end

        drain_requests();
        repeat (40) @(negedge clk);
        if (mismatch_count == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
